// File: hw/rtl/aligned_bump_allocator_with_mark_stack_assert.svh
// Assertion macros for the aligned bump allocator.
`ifndef ALIGNED_BUMP_ALLOCATOR_WITH_MARK_STACK_ASSERT_SVH
`define ALIGNED_BUMP_ALLOCATOR_WITH_MARK_STACK_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ABUMP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aligned bump allocator: assertion failed");
// Next-cycle implication.
`define ABUMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aligned bump allocator: assertion failed");
`else
`define ABUMP_ASSERT(label, ante, cons)
`define ABUMP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/abump_pkg.sv
// Shared types and codes of the aligned bump allocator.
`timescale 1ns / 1ps
package abump_pkg;

  localparam int FIELD_W  = 32;
  localparam int ALIGN_W  = 32;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 2;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CMD_W-1:0]    cmd_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_NO_SPACE   = 3'd1;
  localparam status_t ST_ZERO_ALIGN = 3'd2;
  localparam status_t ST_POP_EMPTY  = 3'd3;
  localparam status_t ST_STACK_FULL = 3'd4;

  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_POP   = 2'd1;
  localparam cmd_t CMD_RESET = 2'd2;

endpackage

// File: hw/rtl/abump_div.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module abump_div #(
  parameter int DVD_W = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [abump_pkg::ALIGN_W-1:0] divisor,
  output logic                         done,
  output logic [abump_pkg::ALIGN_W-1:0] remainder
);

  localparam int DW   = abump_pkg::ALIGN_W;
  localparam int CNTW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0]    dsr_r, dsr_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      partial;
  logic [DW:0]      diff;

  assign partial = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = partial - {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNTW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      // keep the trial difference when it did not go negative
      rem_nxt = diff[DW] ? partial[DW-1:0] : diff[DW-1:0];
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/aligned_bump_allocator_with_mark_stack.sv
// Aligned bump allocator with a mark stack: top level.
// Steps per request: allocate goes through decode, the bit-serial remainder
//   unit (one fill bit per cycle), pad, sum, check and finish; pop goes through
//   decode, the registered stack read and finish; reset, unused code and allocate rejected early go to finish.
// One request in flight: a new request is taken only in idle, after finish.
// rst_n (sync, active low) clears fill, count, arena and handshakes, not the stack.
`timescale 1ns / 1ps
`include "aligned_bump_allocator_with_mark_stack_assert.svh"
module aligned_bump_allocator_with_mark_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abump_pkg::FIELD_W-1:0]   cfg_arena_size,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abump_pkg::CMD_W-1:0]     in_command,
  input  logic [abump_pkg::FIELD_W-1:0]   in_req_size,
  input  logic [abump_pkg::ALIGN_W-1:0]   in_alignment,
  // result channel
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [abump_pkg::STATUS_W-1:0]  out_status,
  output logic [abump_pkg::FIELD_W-1:0]   out_alloc_offset,
  output logic [abump_pkg::FIELD_W-1:0]   out_fill_after
);

  localparam int OW   = OFFSET_BITS;
  localparam int FW   = abump_pkg::FIELD_W;
  localparam int AL   = abump_pkg::ALIGN_W;
  // compare width: size + pad needs 33 bits, remaining needs OW bits
  localparam int CW   = (OW > FW + 1) ? OW : FW + 1;
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DIVIDE = 3'd2;
  localparam logic [2:0] S_PAD    = 3'd3;
  localparam logic [2:0] S_SUM    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_POP    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [OW-1:0]            arena_r, arena_nxt;
  logic [OW-1:0]            fill_r, fill_nxt;
  logic [CNTW-1:0]          count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // latched request
  abump_pkg::cmd_t          cmd_r;
  logic [FW-1:0]            size_r;
  logic [AL-1:0]            align_r;

  // allocate datapath
  logic [AL-1:0]            pad_r, pad_nxt;
  logic [OW-1:0]            remaining_r, remaining_nxt;
  logic [CW-1:0]            need_r, need_nxt;
  logic [OW-1:0]            aligned_r, aligned_nxt;

  // pending result
  abump_pkg::status_t       res_status_r, res_status_nxt;
  logic [OW-1:0]            res_offset_r, res_offset_nxt;

  // output register
  abump_pkg::status_t       out_status_r;
  logic [FW-1:0]            out_offset_r;
  logic [FW-1:0]            out_fill_r;

  // mark stack memory
  logic [OW-1:0]            stack_mem [STACK_DEPTH];
  logic [OW-1:0]            rd_data_r;
  logic [CNTW-1:0]          cnt_dec;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     rd_en;
  logic                     push;

  logic                     div_start;
  logic                     div_done;
  logic [AL-1:0]            div_rem;

  logic                     in_take;
  logic                     out_load;
  logic                     stack_full;

  abump_div #(
    .DVD_W (OW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (fill_r),
    .divisor   (align_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign in_take    = in_valid && in_ready;
  assign out_load   = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign cnt_dec    = count_r - CNTW'(1);
  assign rd_addr    = cnt_dec[AW-1:0];
  assign wr_addr    = count_r[AW-1:0];
  assign stack_full = (count_r == CNTW'(STACK_DEPTH));

  always_comb begin
    state_nxt      = state_r;
    arena_nxt      = arena_r;
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    pad_nxt        = pad_r;
    remaining_nxt  = remaining_r;
    need_nxt       = need_r;
    aligned_nxt    = aligned_r;
    res_status_nxt = res_status_r;
    res_offset_nxt = res_offset_r;
    div_start      = 1'b0;
    rd_en          = 1'b0;
    push           = 1'b0;

    if (cfg_valid && cfg_ready) begin
      arena_nxt = OW'(cfg_arena_size);
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_nxt = abump_pkg::ST_OK;
        res_offset_nxt = '0;
        state_nxt      = S_FINISH;
        unique case (cmd_r)
          abump_pkg::CMD_ALLOC: begin
            // zero alignment wins over every other check
            if (align_r == '0) begin
              res_status_nxt = abump_pkg::ST_ZERO_ALIGN;
            end else if (fill_r >= arena_r) begin
              res_status_nxt = abump_pkg::ST_NO_SPACE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIVIDE;
            end
          end
          abump_pkg::CMD_POP: begin
            if (count_r == '0) begin
              res_status_nxt = abump_pkg::ST_POP_EMPTY;
            end else begin
              rd_en     = 1'b1;
              count_nxt = cnt_dec;
              state_nxt = S_POP;
            end
          end
          abump_pkg::CMD_RESET: begin
            fill_nxt  = '0;
            count_nxt = '0;
          end
          default: begin
            // unused code: no state change, ok status
          end
        endcase
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        pad_nxt       = (div_rem == '0) ? '0 : (align_r - div_rem);
        remaining_nxt = arena_r - fill_r;
        state_nxt     = S_SUM;
      end
      S_SUM: begin
        need_nxt    = CW'(size_r) + CW'(pad_r);
        aligned_nxt = OW'(CW'(fill_r) + CW'(pad_r));
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_FINISH;
        if (need_r > CW'(remaining_r)) begin
          res_status_nxt = abump_pkg::ST_NO_SPACE;
        end else if (stack_full) begin
          res_status_nxt = abump_pkg::ST_STACK_FULL;
        end else begin
          push           = 1'b1;
          count_nxt      = count_r + CNTW'(1);
          res_offset_nxt = aligned_r;
          fill_nxt       = OW'(CW'(aligned_r) + CW'(size_r));
        end
      end
      S_POP: begin
        fill_nxt  = rd_data_r;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arena_r     <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arena_r     <= arena_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= in_command;
      size_r  <= in_req_size;
      align_r <= in_alignment;
    end
    pad_r        <= pad_nxt;
    remaining_r  <= remaining_nxt;
    need_r       <= need_nxt;
    aligned_r    <= aligned_nxt;
    res_status_r <= res_status_nxt;
    res_offset_r <= res_offset_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_offset_r <= FW'(res_offset_r);
      out_fill_r   <= FW'(fill_r);
    end
  end

  // mark stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[wr_addr] <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_alloc_offset = out_offset_r;
  assign out_fill_after   = out_fill_r;

  // mark count never passes the stack depth
  `ABUMP_ASSERT(a_count_bound, 1'b1, count_r <= CNTW'(STACK_DEPTH))
  // remainder unit only finishes while the sequencer waits for it
  `ABUMP_ASSERT(a_div_done_state, div_done, state_r == S_DIVIDE)
  // a push keeps the fill inside the arena and bumps the count by one
  `ABUMP_ASSERT_NEXT(a_push_fits, push,
                     (fill_r <= arena_r) && (count_r == $past(count_r) + CNTW'(1)))

endmodule
